>>> hw/rtl/slfr_pkg.sv
package slfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HUNT_A = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT_B = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MSG    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KIND   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ID     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LEN    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd6;

    typedef struct packed {
        logic       last;
        logic       has_payload;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic [7:0] frame_length;
        logic [7:0] item_id;
        logic [7:0] item_kind;
        logic [7:0] message_type;
    } slfr_result_t;

endpackage

>>> hw/rtl/slfr_parser.sv
module slfr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output slfr_pkg::slfr_result_t res
);
    import slfr_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         msg_reg, msg_next;
    logic [7:0]         kind_reg, kind_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        msg_next   = msg_reg;
        kind_next  = kind_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res.message_type = msg_reg;
        res.item_kind    = kind_reg;
        res.item_id      = id_reg;
        res.frame_length = len_reg;
        res.payload_byte = 8'd0;
        res.byte_index   = 8'd0;
        res.has_payload  = 1'b0;
        res.last         = 1'b0;
        case (phase_reg)
            PH_HUNT_A:
            begin
                phase_next = (rx_byte == SYNC_FIRST) ? PH_HUNT_B : PH_HUNT_A;
            end
            PH_HUNT_B:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    phase_next = PH_MSG;
                end
                else
                begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_HUNT_B : PH_HUNT_A;
                end
            end
            PH_MSG:
            begin
                msg_next   = rx_byte;
                phase_next = PH_KIND;
            end
            PH_KIND:
            begin
                kind_next  = rx_byte;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next         = rx_byte;
                count_next       = 8'd0;
                res.frame_length = rx_byte;
                if (rx_byte == 8'd0)
                begin
                    res_valid  = 1'b1;
                    res.last   = 1'b1;
                    phase_next = PH_HUNT_A;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                count_next       = count_inc;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_index   = count_reg;
                res.has_payload  = 1'b1;
                res.last         = (count_inc >= len_reg);
                if (count_inc >= len_reg)
                begin
                    phase_next = PH_HUNT_A;
                end
            end
            default:
            begin
                phase_next = PH_HUNT_A;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_A;
            msg_reg   <= 8'd0;
            kind_reg  <= 8'd0;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            msg_reg   <= msg_next;
            kind_reg  <= kind_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/sync_length_frame_receiver.sv
// Channel  Direction  tdata                          tuser        tlast
// s_axis   in         rx_byte[7:0]                   -            -
// m_axis   out        header, payload, index [47:0]  has_payload  last
//
// One byte is accepted per cycle while the result side is not stalled.
// An input register and a result register bracket the frame state machine.
// Reset is asynchronous and active low; it returns the block to the sync hunt.
// A stalled result holds the pipeline, and the input register takes a byte only while empty.
module sync_length_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // message_type, item_kind, item_id, frame_length, payload_byte, byte_index
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,  // has_payload
    output logic        m_axis_tlast   // last
);
    import slfr_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    slfr_result_t out_reg;
    logic         advance;
    logic         res_valid;
    slfr_result_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    slfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.byte_index, out_reg.payload_byte, out_reg.frame_length,
                            out_reg.item_id, out_reg.item_kind, out_reg.message_type};
    assign m_axis_tuser  = out_reg.has_payload;
    assign m_axis_tlast  = out_reg.last;

endmodule
